@@ hw/rtl/per_peer_nonce_counter_replay_guard_assert.svh @@
// Assertion macros used by the checker file of this block.
`ifndef PER_PEER_NONCE_COUNTER_REPLAY_GUARD_ASSERT_SVH
`define PER_PEER_NONCE_COUNTER_REPLAY_GUARD_ASSERT_SVH

// Same-cycle implication, muted during reset.
`define PPNRG_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, muted during reset.
`define PPNRG_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/ppnrg_pkg.sv @@
`default_nettype none

package ppnrg_pkg;

  // Replay window geometry.
  localparam int WINDOW = 64;
  localparam int WIN_IDX_W = 6;

  // Item modes.
  localparam logic [1:0] MODE_SEND_CLIENT = 2'd0;
  localparam logic [1:0] MODE_SEND_PEER   = 2'd1;
  localparam logic [1:0] MODE_RECEIVE     = 2'd2;

  // Direction bytes of received nonces.
  localparam logic [7:0] DIR_FROM_CLIENT = 8'h00;
  localparam logic [7:0] DIR_FROM_SERVER = 8'h01;

  // Direction bit placed in outbound nonces.
  localparam logic NONCE_DIR_CLIENT = 1'b0;
  localparam logic NONCE_DIR_SERVER = 1'b1;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_SHORT   = 3'd1,
    ST_LONG    = 3'd2,
    ST_BAD_DIR = 3'd3,
    ST_OLD     = 3'd4,
    ST_DUP     = 3'd5
  } status_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [3:0]  peer_slot;
    logic [7:0]  direction_byte;
    logic [63:0] packet_counter;
    logic [15:0] packet_length;
    logic [15:0] capacity;
  } in_item_t;

  typedef struct packed {
    logic        accepted;
    status_t     status;
    logic [63:0] nonce_counter;
    logic        nonce_direction;
    logic [15:0] plaintext_length;
  } out_item_t;

  // One peer slot as stored in the table memory.
  typedef struct packed {
    logic [63:0] outbound;
    logic [63:0] highest;
    logic [63:0] mask;
  } peer_entry_t;

  // Verdict and updated window from the replay check.
  typedef struct packed {
    status_t     status;
    logic [63:0] highest;
    logic [63:0] mask;
  } win_res_t;

endpackage

`default_nettype wire

@@ hw/rtl/ppnrg_stream_if.sv @@
`default_nettype none

// Valid/ready channel; a transfer happens when valid and ready are both high.
interface ppnrg_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/per_peer_nonce_counter_replay_guard.sv @@
// An accepted item is held while its peer slot is read; its result is then registered.
// No item is taken while another executes: the peer table RAM needs a read-modify-write.
// A waiting result holds off the next request transfer until the result is taken.
// Reset (synchronous, active high) zeroes the client context and then clears the peer
// table in one pass over its slots, one slot a cycle, during which no item is taken.
`default_nettype none

module per_peer_nonce_counter_replay_guard #(
  parameter int NUM_PEERS      = 16,
  parameter int OVERHEAD_BYTES = 28
) (
  input logic           clk,
  input logic           rst,
  ppnrg_stream_if.sink   req,
  ppnrg_stream_if.source rsp
);
  import ppnrg_pkg::*;

  localparam int SLOT_W = (NUM_PEERS > 1) ? $clog2(NUM_PEERS) : 1;
  localparam logic [15:0] OVERHEAD = 16'(OVERHEAD_BYTES);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_PEERS - 1);

  typedef enum logic [2:0] {
    FSM_CLEAR = 3'b001,
    FSM_IDLE  = 3'b010,
    FSM_EXEC  = 3'b100
  } fsm_t;

  fsm_t        state;
  fsm_t        state_next;
  logic [SLOT_W-1:0] clr_cnt;

  in_item_t    item;
  logic [SLOT_W-1:0] slot;
  logic [SLOT_W-1:0] slot_map [16];

  logic [63:0] client_outbound;
  logic [63:0] client_highest;
  logic [63:0] client_seen_mask;

  logic        req_fire;
  logic        rsp_fire;

  logic        ram_we;
  logic [SLOT_W-1:0] ram_waddr;
  peer_entry_t ram_wdata;
  peer_entry_t ram_rdata;

  logic [63:0] win_hi;
  logic [63:0] win_mask;
  win_res_t    win;

  out_item_t   result;
  logic        peer_we;
  peer_entry_t peer_new;
  logic        client_out_we;
  logic        client_win_we;
  logic [15:0] pt_len;

  logic        out_valid;
  out_item_t   out_data;

  // Slot numbers fold onto the table size.
  for (genvar i = 0; i < 16; i++) begin : g_slot_map
    assign slot_map[i] = SLOT_W'(i % NUM_PEERS);
  end

  assign req_fire  = req.valid && req.ready;
  assign rsp_fire  = out_valid && rsp.ready;
  assign req.ready = (state == FSM_IDLE) && (!out_valid || rsp.ready);

  // Sequencer: clearing pass, then one table access per item.
  always_comb begin
    state_next = state;
    case (state)
      FSM_CLEAR: begin
        if (clr_cnt == LAST_SLOT) begin
          state_next = FSM_IDLE;
        end
      end
      FSM_IDLE: begin
        if (req_fire) begin
          state_next = FSM_EXEC;
        end
      end
      FSM_EXEC: begin
        state_next = FSM_IDLE;
      end
      default: begin
        state_next = FSM_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= FSM_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == FSM_CLEAR) begin
        clr_cnt <= clr_cnt + SLOT_W'(1);
      end
    end
  end

  // Hold the accepted item while its slot is read.
  always_ff @(posedge clk) begin
    if (req_fire) begin
      item <= req.payload;
      slot <= slot_map[req.payload.peer_slot];
    end
  end

  // Peer table memory.
  assign ram_we    = (state == FSM_CLEAR) || peer_we;
  assign ram_waddr = (state == FSM_CLEAR) ? clr_cnt : slot;
  assign ram_wdata = (state == FSM_CLEAR) ? '0 : peer_new;

  ppnrg_ram #(
    .WIDTH ($bits(peer_entry_t)),
    .DEPTH (NUM_PEERS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (req_fire),
    .raddr (slot_map[req.payload.peer_slot]),
    .rdata (ram_rdata)
  );

  // One replay checker serves both contexts.
  assign win_hi   = (item.direction_byte == DIR_FROM_SERVER) ? client_highest
                                                             : ram_rdata.highest;
  assign win_mask = (item.direction_byte == DIR_FROM_SERVER) ? client_seen_mask
                                                             : ram_rdata.mask;

  ppnrg_window u_window (
    .highest (win_hi),
    .mask    (win_mask),
    .counter (item.packet_counter),
    .res     (win)
  );

  assign pt_len = item.packet_length - OVERHEAD;

  // Execute the held item against the state that was read.
  always_comb begin
    result        = '0;
    result.status = ST_OK;
    peer_new      = ram_rdata;
    peer_we       = 1'b0;
    client_out_we = 1'b0;
    client_win_we = 1'b0;
    if (state == FSM_EXEC) begin
      case (item.mode)
        MODE_SEND_CLIENT: begin
          result.accepted        = 1'b1;
          result.nonce_counter   = client_outbound;
          result.nonce_direction = NONCE_DIR_CLIENT;
          client_out_we          = 1'b1;
        end
        MODE_SEND_PEER: begin
          result.accepted        = 1'b1;
          result.nonce_counter   = ram_rdata.outbound;
          result.nonce_direction = NONCE_DIR_SERVER;
          peer_new.outbound      = ram_rdata.outbound + 64'd1;
          peer_we                = 1'b1;
        end
        MODE_RECEIVE: begin
          if (item.packet_length < OVERHEAD) begin
            result.status = ST_SHORT;
          end else if (pt_len > item.capacity) begin
            result.status = ST_LONG;
          end else if (item.direction_byte == DIR_FROM_CLIENT) begin
            result.status    = win.status;
            peer_new.highest = win.highest;
            peer_new.mask    = win.mask;
            peer_we          = (win.status == ST_OK);
          end else if (item.direction_byte == DIR_FROM_SERVER) begin
            result.status = win.status;
            client_win_we = (win.status == ST_OK);
          end else begin
            result.status = ST_BAD_DIR;
          end
          if (result.status == ST_OK) begin
            result.accepted         = 1'b1;
            result.plaintext_length = pt_len;
          end
        end
        default: begin
          result = '0;
        end
      endcase
    end
  end

  // Client context registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      client_outbound  <= '0;
      client_highest   <= '0;
      client_seen_mask <= '0;
    end else begin
      if (client_out_we) begin
        client_outbound <= client_outbound + 64'd1;
      end
      if (client_win_we) begin
        client_highest   <= win.highest;
        client_seen_mask <= win.mask;
      end
    end
  end

  // Output register; it is always free when an item finishes.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == FSM_EXEC) begin
      out_valid <= 1'b1;
    end else if (rsp_fire) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == FSM_EXEC) begin
      out_data <= result;
    end
  end

  assign rsp.valid   = out_valid;
  assign rsp.payload = out_data;

endmodule

`default_nettype wire

@@ hw/rtl/ppnrg_ram.sv @@
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
module ppnrg_ram #(
  parameter int WIDTH = 192,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/ppnrg_window.sv @@
`default_nettype none

// 64-wide sliding-window replay check on one context.
module ppnrg_window (
  input  logic [63:0]          highest,
  input  logic [63:0]          mask,
  input  logic [63:0]          counter,
  output ppnrg_pkg::win_res_t  res
);
  import ppnrg_pkg::*;

  logic [63:0] fwd_dist;
  logic [63:0] back_dist;
  logic        ahead;
  logic        too_old;
  logic        far;
  logic [63:0] shifted;
  logic [63:0] seen_bit;

  assign fwd_dist  = counter - highest;
  assign back_dist = highest - counter;
  assign ahead     = counter > highest;

  // At or behind the top, a distance of a full window or more is stale.
  assign too_old = !ahead && (back_dist >= 64'(WINDOW));

  // Moving the top up slides the mask; a jump past the window empties it.
  assign far      = fwd_dist[63:WIN_IDX_W] != '0;
  assign shifted  = far ? '0 : (mask << fwd_dist[WIN_IDX_W-1:0]);
  assign seen_bit = 64'd1 << back_dist[WIN_IDX_W-1:0];

  always_comb begin
    res.status  = ST_OK;
    res.highest = highest;
    res.mask    = mask;
    if (too_old) begin
      res.status = ST_OLD;
    end else if (ahead) begin
      res.highest = counter;
      res.mask    = shifted | 64'd1;
    end else if ((mask & seen_bit) != '0) begin
      res.status = ST_DUP;
    end else begin
      res.mask = mask | seen_bit;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/ppnrg_checker.sv @@
`default_nettype none
`include "per_peer_nonce_counter_replay_guard_assert.svh"

// Port-level checks on the guard's handshakes and results.
module ppnrg_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 req_valid,
  input logic                 req_ready,
  input logic                 rsp_valid,
  input logic                 rsp_ready,
  input ppnrg_pkg::out_item_t rsp_payload
);
  import ppnrg_pkg::*;

  logic req_xfer;

  assign req_xfer = req_valid && req_ready;

  // A result stays offered until it is taken.
  `PPNRG_ASSERT_NXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid,
    "result dropped while stalled")

  // The table access interlocks: no request transfer right after another.
  `PPNRG_ASSERT_NXT(a_req_gap, clk, rst, req_xfer, !req_ready,
    "request taken during table access")

  // An accepted request has its result offered after the table access, and none during it.
  `PPNRG_ASSERT_NXT(a_rsp_follows, clk, rst, req_xfer, !rsp_valid ##1 rsp_valid,
    "result missing after request")

  // An accepted item always carries the ok status.
  `PPNRG_ASSERT_IMP(a_acc_ok, clk, rst, rsp_valid && rsp_payload.accepted,
    rsp_payload.status == ST_OK, "accepted item with error status")

endmodule

bind per_peer_nonce_counter_replay_guard ppnrg_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .rsp_payload (rsp.payload)
);

`default_nettype wire

@@ sim/tb_top.sv @@
module tb_top;
  import ppnrg_pkg::*;

  localparam int NUM_PEERS  = 16;
  localparam int OVERHEAD   = 28;
  localparam int IDLE_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 950;
  localparam int SETTLE_CYCLES = 10;

  // The mode encoding that the block leaves undefined.
  localparam logic [1:0] MODE_UNDEFINED = 2'd3;
  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam out_item_t NO_RESULT = '0;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t result;
  } vector_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ppnrg_stream_if #(.payload_t(in_item_t))  req_if ();
  ppnrg_stream_if #(.payload_t(out_item_t)) rsp_if ();

  per_peer_nonce_counter_replay_guard #(
    .NUM_PEERS      (NUM_PEERS),
    .OVERHEAD_BYTES (OVERHEAD)
  ) dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the counter and window state.
  logic [63:0] client_next;
  logic [63:0] client_hi;
  logic [63:0] client_seen;
  logic [63:0] peer_next [NUM_PEERS];
  logic [63:0] peer_hi   [NUM_PEERS];
  logic [63:0] peer_seen [NUM_PEERS];

  out_item_t pending_verdicts [$];
  vector_t   directed_rows [$];
  int        error_count = 0;
  int        burst_left = 0;

  // Sliding-window replay check on one context; the caller commits on ST_OK.
  function automatic win_res_t slide_window(logic [63:0] hi, logic [63:0] m,
                                            logic [63:0] ctr);
    win_res_t    res;
    logic [63:0] diff;
    res.status = ST_OK;
    if (hi >= WINDOW && ctr <= hi - WINDOW) begin
      res.status = ST_OLD;
    end else begin
      if (ctr > hi) begin
        m  = (ctr - hi >= WINDOW) ? 64'd0 : (m << (ctr - hi));
        hi = ctr;
      end
      diff = hi - ctr;
      if (diff < WINDOW) begin
        if (m[diff[5:0]]) begin
          res.status = ST_DUP;
        end else begin
          m[diff[5:0]] = 1'b1;
        end
      end
    end
    res.highest = hi;
    res.mask    = m;
    return res;
  endfunction

  // Computes the verdict for one accepted item and advances the shadow state.
  function automatic out_item_t advance_guard(in_item_t it);
    out_item_t res;
    win_res_t  win;
    res = '0;
    case (it.mode)
      MODE_SEND_CLIENT: begin
        res.accepted        = 1'b1;
        res.nonce_counter   = client_next;
        res.nonce_direction = NONCE_DIR_CLIENT;
        client_next         = client_next + 64'd1;
      end
      MODE_SEND_PEER: begin
        res.accepted            = 1'b1;
        res.nonce_counter       = peer_next[it.peer_slot];
        res.nonce_direction     = NONCE_DIR_SERVER;
        peer_next[it.peer_slot] = peer_next[it.peer_slot] + 64'd1;
      end
      MODE_RECEIVE: begin
        if (it.packet_length < OVERHEAD) begin
          res.status = ST_SHORT;
        end else if (it.packet_length - OVERHEAD > it.capacity) begin
          res.status = ST_LONG;
        end else if (it.direction_byte == DIR_FROM_CLIENT) begin
          win = slide_window(peer_hi[it.peer_slot], peer_seen[it.peer_slot],
                             it.packet_counter);
          res.status = win.status;
          if (win.status == ST_OK) begin
            peer_hi[it.peer_slot]   = win.highest;
            peer_seen[it.peer_slot] = win.mask;
          end
        end else if (it.direction_byte == DIR_FROM_SERVER) begin
          win = slide_window(client_hi, client_seen, it.packet_counter);
          res.status = win.status;
          if (win.status == ST_OK) begin
            client_hi   = win.highest;
            client_seen = win.mask;
          end
        end else begin
          res.status = ST_BAD_DIR;
        end
        if (res.status == ST_OK) begin
          res.accepted         = 1'b1;
          res.plaintext_length = 16'(it.packet_length - OVERHEAD);
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic in_item_t mk_in(logic [1:0] mode, logic [3:0] slot, logic [7:0] dir,
                                     logic [63:0] ctr, logic [15:0] len, logic [15:0] cap);
    in_item_t it;
    it.mode           = mode;
    it.peer_slot      = slot;
    it.direction_byte = dir;
    it.packet_counter = ctr;
    it.packet_length  = len;
    it.capacity       = cap;
    return it;
  endfunction

  function automatic out_item_t mk_out(logic acc, status_t st, logic [63:0] ctr,
                                       logic ndir, logic [15:0] ptlen);
    out_item_t res;
    res.accepted         = acc;
    res.status           = st;
    res.nonce_counter    = ctr;
    res.nonce_direction  = ndir;
    res.plaintext_length = ptlen;
    return res;
  endfunction

  // Mostly well-formed traffic aimed at the current window edge, plus noise.
  function automatic in_item_t random_item();
    in_item_t    it;
    int          pick;
    int          aim;
    int          off;
    int          room;
    int          plain;
    logic [63:0] base;
    logic [64:0] sum;
    pick = $urandom_range(0, 99);
    it.mode           = MODE_RECEIVE;
    it.peer_slot      = 4'($urandom_range(0, NUM_PEERS - 1));
    it.direction_byte = $urandom_range(0, 1) ? DIR_FROM_SERVER : DIR_FROM_CLIENT;
    it.packet_counter = {$urandom, $urandom};
    it.capacity       = 16'($urandom);
    room = it.capacity;
    if (room > 65535 - OVERHEAD) begin
      room = 65535 - OVERHEAD;
    end
    plain = ($urandom_range(0, 3) == 0) ? room : int'($urandom_range(0, room));
    it.packet_length = 16'(plain + OVERHEAD);
    if (pick < 14) begin
      it.mode = MODE_SEND_CLIENT;
    end else if (pick < 28) begin
      it.mode = MODE_SEND_PEER;
    end else if (pick < 84) begin
      base = (it.direction_byte == DIR_FROM_SERVER) ? client_hi : peer_hi[it.peer_slot];
      aim  = $urandom_range(0, 99);
      if (aim < 60) begin
        off = int'($urandom_range(0, 80)) - 70;
      end else if (aim < 85) begin
        off = $urandom_range(1, 3);
      end else begin
        off = $urandom_range(64, 300);
      end
      // A few receives keep the fully random counter to move the window far.
      if (aim < 95 || pick >= 80) begin
        if (off < 0) begin
          it.packet_counter = (base >= 64'(-off)) ? base - 64'(-off)
                                                  : 64'($urandom_range(0, 3));
        end else begin
          sum = {1'b0, base} + 65'(off);
          it.packet_counter = sum[64] ? ALL_ONES : sum[63:0];
        end
      end
    end else begin
      it.mode           = 2'($urandom);
      it.direction_byte = 8'($urandom);
      it.packet_length  = $urandom_range(0, 1) ? 16'($urandom)
                                               : 16'($urandom_range(0, OVERHEAD - 1));
    end
    return it;
  endfunction

  function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      error_count++;
      $error("%s: expected %0h, got %0h", name, want, got);
    end
  endfunction

  // Drives one item in the current burst and records its verdict at the transfer.
  task automatic transfer_item(input in_item_t it, input bit typed, input out_item_t res);
    int        gap;
    out_item_t predicted;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    req_if.valid   <= 1'b1;
    req_if.payload <= it;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    predicted = advance_guard(it);
    pending_verdicts.push_back(typed ? res : predicted);
  endtask

  // Holds off the sender until every outstanding result has come back.
  task automatic drain_pause();
    req_if.valid <= 1'b0;
    do @(posedge clk); while (pending_verdicts.size() != 0);
  endtask

  // Directed items: extremes, every mode, and the window corner cases.
  initial begin
    directed_rows.push_back(vector_t'{mk_in(MODE_SEND_CLIENT, 4'h0, 8'h00, 64'd0, 16'd0, 16'd0),
      1'b1, mk_out(1'b1, ST_OK, 64'd0, NONCE_DIR_CLIENT, 16'd0)});
    directed_rows.push_back(vector_t'{mk_in(MODE_SEND_PEER, 4'hF, 8'h00, 64'd0, 16'd0, 16'd0),
      1'b1, mk_out(1'b1, ST_OK, 64'd0, NONCE_DIR_SERVER, 16'd0)});
    directed_rows.push_back(vector_t'{mk_in(MODE_SEND_PEER, 4'hF, 8'h00, 64'd0, 16'd0, 16'd0),
      1'b1, mk_out(1'b1, ST_OK, 64'd1, NONCE_DIR_SERVER, 16'd0)});
    // Length checks come before the direction check.
    directed_rows.push_back(vector_t'{mk_in(MODE_RECEIVE, 4'h0, DIR_FROM_SERVER, 64'd5,
      16'd27, 16'hFFFF), 1'b1, mk_out(1'b0, ST_SHORT, 64'd0, 1'b0, 16'd0)});
    directed_rows.push_back(vector_t'{mk_in(MODE_RECEIVE, 4'h0, 8'hFF, 64'd5,
      16'd0, 16'd0), 1'b1, mk_out(1'b0, ST_SHORT, 64'd0, 1'b0, 16'd0)});
    directed_rows.push_back(vector_t'{mk_in(MODE_RECEIVE, 4'h0, DIR_FROM_SERVER, 64'd5,
      16'hFFFF, 16'hFFE2), 1'b1, mk_out(1'b0, ST_LONG, 64'd0, 1'b0, 16'd0)});
    directed_rows.push_back(vector_t'{mk_in(MODE_RECEIVE, 4'h0, 8'h02, 64'd5,
      16'd28, 16'd0), 1'b1, mk_out(1'b0, ST_BAD_DIR, 64'd0, 1'b0, 16'd0)});
    directed_rows.push_back(vector_t'{mk_in(MODE_RECEIVE, 4'h3, 8'hFF, ALL_ONES,
      16'hFFFF, 16'hFFFF), 1'b1, mk_out(1'b0, ST_BAD_DIR, 64'd0, 1'b0, 16'd0)});
    // Counter zero on a fresh context, then its replay.
    directed_rows.push_back(vector_t'{mk_in(MODE_RECEIVE, 4'h0, DIR_FROM_SERVER, 64'd0,
      16'd28, 16'd0), 1'b1, mk_out(1'b1, ST_OK, 64'd0, 1'b0, 16'd0)});
    directed_rows.push_back(vector_t'{mk_in(MODE_RECEIVE, 4'h0, DIR_FROM_SERVER, 64'd0,
      16'd28, 16'd0), 1'b1, mk_out(1'b0, ST_DUP, 64'd0, 1'b0, 16'd0)});
    directed_rows.push_back(vector_t'{mk_in(MODE_RECEIVE, 4'h0, DIR_FROM_SERVER, 64'd1,
      16'hFFFF, 16'hFFFF), 1'b1, mk_out(1'b1, ST_OK, 64'd0, 1'b0, 16'hFFE3)});
    // Largest counter on a peer slot, then the edges of its window.
    directed_rows.push_back(vector_t'{mk_in(MODE_RECEIVE, 4'hF, DIR_FROM_CLIENT, ALL_ONES,
      16'd100, 16'd72), 1'b1, mk_out(1'b1, ST_OK, 64'd0, 1'b0, 16'd72)});
    directed_rows.push_back(vector_t'{mk_in(MODE_RECEIVE, 4'hF, DIR_FROM_CLIENT, 64'd0,
      16'd28, 16'd0), 1'b1, mk_out(1'b0, ST_OLD, 64'd0, 1'b0, 16'd0)});
    directed_rows.push_back(vector_t'{mk_in(MODE_RECEIVE, 4'hF, DIR_FROM_CLIENT, ALL_ONES - 64,
      16'd28, 16'd0), 1'b1, mk_out(1'b0, ST_OLD, 64'd0, 1'b0, 16'd0)});
    directed_rows.push_back(vector_t'{mk_in(MODE_RECEIVE, 4'hF, DIR_FROM_CLIENT, ALL_ONES - 63,
      16'd28, 16'd0), 1'b1, mk_out(1'b1, ST_OK, 64'd0, 1'b0, 16'd0)});
    directed_rows.push_back(vector_t'{mk_in(MODE_RECEIVE, 4'hF, DIR_FROM_CLIENT, ALL_ONES - 63,
      16'd28, 16'd0), 1'b1, mk_out(1'b0, ST_DUP, 64'd0, 1'b0, 16'd0)});
    // Out-of-order counters, a window jump, and the new lower edge.
    directed_rows.push_back(vector_t'{mk_in(MODE_RECEIVE, 4'h0, DIR_FROM_CLIENT, 64'd40,
      16'd60, 16'd40), 1'b0, NO_RESULT});
    directed_rows.push_back(vector_t'{mk_in(MODE_RECEIVE, 4'h0, DIR_FROM_CLIENT, 64'd10,
      16'd60, 16'd40), 1'b0, NO_RESULT});
    directed_rows.push_back(vector_t'{mk_in(MODE_RECEIVE, 4'h0, DIR_FROM_CLIENT, 64'd104,
      16'd60, 16'd40), 1'b0, NO_RESULT});
    directed_rows.push_back(vector_t'{mk_in(MODE_RECEIVE, 4'h0, DIR_FROM_CLIENT, 64'd40,
      16'd60, 16'd40), 1'b0, NO_RESULT});
    directed_rows.push_back(vector_t'{mk_in(MODE_RECEIVE, 4'h0, DIR_FROM_CLIENT, 64'd41,
      16'd60, 16'd40), 1'b0, NO_RESULT});
    directed_rows.push_back(vector_t'{mk_in(MODE_UNDEFINED, 4'hF, 8'hFF, ALL_ONES,
      16'hFFFF, 16'hFFFF), 1'b1, NO_RESULT});
    directed_rows.push_back(vector_t'{mk_in(MODE_SEND_CLIENT, 4'h0, 8'h00, 64'd0, 16'd0, 16'd0),
      1'b1, mk_out(1'b1, ST_OK, 64'd1, NONCE_DIR_CLIENT, 16'd0)});
    directed_rows.push_back(vector_t'{mk_in(MODE_SEND_PEER, 4'h0, 8'h00, 64'd0, 16'd0, 16'd0),
      1'b1, mk_out(1'b1, ST_OK, 64'd0, NONCE_DIR_SERVER, 16'd0)});
    directed_rows.push_back(vector_t'{mk_in(MODE_RECEIVE, 4'h7, DIR_FROM_SERVER, ALL_ONES,
      16'd28, 16'd0), 1'b0, NO_RESULT});
  end

  // Sequence: reset, directed rows, random traffic, then drain.
  initial begin
    client_next = '0;
    client_hi   = '0;
    client_seen = '0;
    foreach (peer_next[i]) begin
      peer_next[i] = '0;
      peer_hi[i]   = '0;
      peer_seen[i] = '0;
    end
    req_if.valid   <= 1'b0;
    req_if.payload <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    foreach (directed_rows[i]) begin
      transfer_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].result);
    end
    drain_pause();
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2) begin
        drain_pause();
      end
      transfer_item(random_item(), 1'b0, NO_RESULT);
    end
    req_if.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Receiver back-pressure: stretches of differing stall density, some with none.
  initial begin
    int stall_run;
    int stall_pct;
    stall_run = 0;
    stall_pct = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_run == 0) begin
        stall_run = $urandom_range(16, 96);
        case ($urandom_range(0, 3))
          0:       stall_pct = 0;
          1:       stall_pct = 30;
          2:       stall_pct = 60;
          default: stall_pct = 85;
        endcase
      end
      stall_run--;
      rsp_if.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Each result transfer is checked against the oldest outstanding verdict.
  always @(posedge clk) begin
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (pending_verdicts.size() == 0) begin
        error_count++;
        $error("result transfer with no verdict outstanding");
      end else begin
        out_item_t want;
        want = pending_verdicts.pop_front();
        compare_field("accepted", want.accepted, rsp_if.payload.accepted);
        compare_field("status", want.status, rsp_if.payload.status);
        compare_field("nonce_counter", want.nonce_counter, rsp_if.payload.nonce_counter);
        compare_field("nonce_direction", want.nonce_direction,
                      rsp_if.payload.nonce_direction);
        compare_field("plaintext_length", want.plaintext_length,
                      rsp_if.payload.plaintext_length);
      end
    end
  end

  // Watchdog: ends the run when no transfer happens on either side for too long.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("end of test: mismatches");
    $finish;
  end

endmodule

@@ per_peer_nonce_counter_replay_guard.f @@
+incdir+hw/rtl
hw/rtl/ppnrg_pkg.sv
hw/rtl/ppnrg_stream_if.sv
hw/rtl/ppnrg_ram.sv
hw/rtl/ppnrg_window.sv
hw/rtl/per_peer_nonce_counter_replay_guard.sv
hw/rtl/ppnrg_checker.sv
sim/tb_top.sv
